/* rtl/core/sra_pkg.sv */
// sra_pkg: types and constants shared by the staging ring allocator
// holds action and status codes, controller state and command types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned SIZE_W   = 29;
  localparam int unsigned ALIGN_W  = 4;
  localparam int unsigned CAP_W    = 29;
  localparam int unsigned OFF_W    = 28;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024 * 1024);

  typedef enum logic [ACT_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_FLUSH   = 2'd1,
    ACT_RETIRE  = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_TOO_LARGE      = 3'd1,
    ST_NO_SPACE       = 3'd2,
    ST_NO_SLOT        = 3'd3,
    ST_NOTHING_FLUSH  = 3'd4,
    ST_NOTHING_RETIRE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_ALIGN  = 2'd1,
    S_DECIDE = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic load_req;  // capture the incoming word
    logic align_en;  // register the aligned tail
    logic commit;    // update state and load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/sra_ifs.sv */
// sra_ifs: request and response channel interfaces of the staging ring allocator
// valid/ready handshake with the payload fields; depends on sra_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sra_req_if;
  import sra_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [SIZE_W-1:0]  req_size;
  logic [ALIGN_W-1:0] align_log2;

  modport source (output valid, action, req_size, align_log2, input ready);
  modport sink   (input valid, action, req_size, align_log2, output ready);
endinterface

interface sra_rsp_if;
  import sra_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    grant_offset;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, grant_offset, status, slot_index, input ready);
  modport sink   (input valid, grant_offset, status, slot_index, output ready);
endinterface

`default_nettype wire

/* rtl/core/sra_ctrl.sv */
// sra_ctrl: sequencing state machine of the staging ring allocator
// drives the handshakes and the datapath commands; depends on sra_pkg
`timescale 1ns / 1ps
`default_nettype none

module sra_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sra_pkg::ctrl_cmd_t     cmd_o
);
  import sra_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_ALIGN;
        end
      end
      S_ALIGN: begin
        cmd_o.align_en = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        // result register must be free or draining this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still held");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_load_then_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> (state_q == S_ALIGN))
    else $error("accepted word not taken to alignment");

endmodule

`default_nettype wire

/* rtl/core/sra_dp.sv */
// sra_dp: pointers, batch slot memory, capacity register and result register
// executes one word per commit from sra_ctrl; depends on sra_pkg
`timescale 1ns / 1ps
`default_nettype none

module sra_dp #(
  parameter int unsigned NUM_SLOTS = 4,
  parameter int unsigned PTR_WIDTH = 29
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sra_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  wire sra_pkg::ctrl_cmd_t             cmd_i,
  input  wire logic [sra_pkg::ACT_W-1:0]      action_i,
  input  wire logic [sra_pkg::SIZE_W-1:0]     req_size_i,
  input  wire logic [sra_pkg::ALIGN_W-1:0]    align_log2_i,
  output logic [sra_pkg::OFF_W-1:0]           grant_offset_o,
  output logic [sra_pkg::STATUS_W-1:0]        status_o,
  output logic [sra_pkg::SLOT_W-1:0]          slot_index_o
);
  import sra_pkg::*;

  localparam int unsigned SI_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned PW_MAX = (PTR_WIDTH > CAP_W) ? PTR_WIDTH : CAP_W;
  // wide enough for tail plus alignment plus size without wrapping
  localparam int unsigned EW     = PW_MAX + 2;
  localparam logic [SI_W-1:0]  LAST_SLOT = SI_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NUM_SLOTS);

  // architectural state
  logic [CAP_W-1:0]     cap_q;
  logic [PTR_WIDTH-1:0] head_q, tail_q, bstart_q;
  logic                 bopen_q;
  logic [SI_W-1:0]      open_slot_q, oldest_q;
  logic [CNT_W-1:0]     pending_q;

  // captured request and aligned tail
  action_e              act_q;
  logic [SIZE_W-1:0]    size_q;
  logic [ALIGN_W-1:0]   alog_q;
  logic [EW-1:0]        cand_q;

  // batch slot memory: start in the upper half, end in the lower half
  logic [2*PTR_WIDTH-1:0] slot_mem [NUM_SLOTS];
  logic [2*PTR_WIDTH-1:0] slot_rd_q;

  // result register
  logic [OFF_W-1:0]    off_out_q;
  status_e             status_q;
  logic [SLOT_W-1:0]   slot_out_q;

  logic [EW-1:0] amask, cand_d;
  logic [EW-1:0] size_e, cap_e, head_e, tail_e, sum;
  logic          fit_cand, fits, idle_ring, acq_ok, wrap_fit;
  logic [EW-1:0] offset;
  logic [PTR_WIDTH-1:0] new_tail, rd_start, rd_end;
  logic [SI_W-1:0] open_next, oldest_next;
  logic [OFF_W-1:0] off_d;
  status_e          status_d;
  logic [SI_W-1:0]  slot_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q  <= action_e'(action_i);
      size_q <= req_size_i;
      alog_q <= align_log2_i;
    end
    if (cmd_i.align_en) begin
      cand_q <= cand_d;
    end
  end

  assign amask  = ~({EW{1'b1}} << alog_q);
  assign tail_e = EW'(tail_q);
  assign cand_d = (tail_e + amask) & ~amask;

  always_ff @(posedge clk_i) begin
    slot_rd_q <= slot_mem[oldest_q];
    if (cmd_i.commit && act_q == ACT_FLUSH && bopen_q) begin
      slot_mem[open_slot_q] <= {bstart_q, tail_q};
    end
  end

  assign rd_start = slot_rd_q[2*PTR_WIDTH-1:PTR_WIDTH];
  assign rd_end   = slot_rd_q[PTR_WIDTH-1:0];

  assign size_e    = EW'(size_q);
  assign cap_e     = EW'(cap_q);
  assign head_e    = EW'(head_q);
  assign sum       = cand_q + size_e;
  assign idle_ring = (pending_q == '0) && !bopen_q;
  assign open_next   = (open_slot_q == LAST_SLOT) ? '0 : open_slot_q + 1'b1;
  assign oldest_next = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;

  // placement decision for an acquire
  always_comb begin
    wrap_fit = 1'b0;
    if (head_q <= tail_q) begin
      fit_cand = (sum <= cap_e);
      wrap_fit = (size_e < head_e);
      fits     = fit_cand || wrap_fit;
    end else begin
      fit_cand = (sum < head_e);
      fits     = fit_cand;
    end
    offset   = fit_cand ? cand_q : '0;
    new_tail = fit_cand ? PTR_WIDTH'(sum) : PTR_WIDTH'(size_e);
    acq_ok   = (size_q <= cap_q) && !(!bopen_q && pending_q == FULL_CNT)
               && (fits || idle_ring);
  end

  always_comb begin
    off_d    = '0;
    status_d = ST_OK;
    slot_d   = open_slot_q;
    unique case (act_q)
      ACT_ACQUIRE: begin
        if (size_q > cap_q) begin
          status_d = ST_TOO_LARGE;
        end else if (!bopen_q && pending_q == FULL_CNT) begin
          status_d = ST_NO_SLOT;
        end else if (!fits && !idle_ring) begin
          status_d = ST_NO_SPACE;
        end else begin
          off_d = OFF_W'(offset);
        end
      end
      ACT_FLUSH: begin
        if (!bopen_q) begin
          status_d = ST_NOTHING_FLUSH;
        end
      end
      ACT_RETIRE: begin
        if (pending_q == '0) begin
          status_d = ST_NOTHING_RETIRE;
        end else begin
          slot_d = oldest_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      bstart_q    <= '0;
      bopen_q     <= 1'b0;
      open_slot_q <= '0;
      oldest_q    <= '0;
      pending_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        case (act_q)
          ACT_ACQUIRE: begin
            if (acq_ok) begin
              // an idle ring that cannot place the word restarts at offset zero
              if (!fits) begin
                head_q <= '0;
              end
              if (!bopen_q) begin
                bstart_q <= PTR_WIDTH'(offset);
                bopen_q  <= 1'b1;
              end
              tail_q <= new_tail;
            end
          end
          ACT_FLUSH: begin
            if (bopen_q) begin
              bopen_q     <= 1'b0;
              pending_q   <= pending_q + 1'b1;
              open_slot_q <= open_next;
            end
          end
          ACT_RETIRE: begin
            if (pending_q != '0) begin
              // an empty batch leaves the head where it is
              if (rd_start != rd_end) begin
                head_q <= rd_end;
              end
              pending_q <= pending_q - 1'b1;
              oldest_q  <= oldest_next;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      off_out_q  <= off_d;
      status_q   <= status_d;
      slot_out_q <= SLOT_W'(slot_d);
    end
  end

  assign grant_offset_o = off_out_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_out_q;

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= FULL_CNT)
    else $error("more batches pending than slots");

  a_flush_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && act_q == ACT_FLUSH && bopen_q) |=> !bopen_q)
    else $error("flush left the batch open");

  a_retire_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && act_q == ACT_RETIRE && pending_q != '0)
    |=> (pending_q == $past(pending_q) - 1'b1))
    else $error("retire did not release a batch");

endmodule

`default_nettype wire

/* rtl/core/staging_ring_allocator.sv */
// staging_ring_allocator: top level of the circular staging buffer allocator
// joins sra_ctrl and sra_dp to the channels; depends on sra_pkg and sra_ifs
//
// usage: each request word carries an action (acquire, flush, retire or no
// operation), a size and an alignment; each produces exactly one response word
// with the granted offset, a status code and a slot index
// the capacity register is to be written through cfg_we_i / cfg_wdata_i only
// while idle; the block does not enforce this; it resets to one megabyte
// sequence: a word accepted on req_i passes the align and decide steps and
// shows on rsp_o in the cycle after its decision; the controller takes a
// new word only after the accept, align and decide steps of the last one
// (the aligned tail is registered before the fit check)
// the block accepts a new word while a response still waits on rsp_o; if the
// receiver stalls, that next word is held at its decide step until the
// response register frees
// reset clears pointers, batch state and counters; the slot memory is not
// cleared, only flushed slots are ever used
`timescale 1ns / 1ps
`default_nettype none

module staging_ring_allocator #(
  parameter int unsigned NUM_SLOTS = 4,
  parameter int unsigned PTR_WIDTH = 29
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [sra_pkg::CAP_W-1:0] cfg_wdata_i,
  sra_req_if.sink                        req_i,
  sra_rsp_if.source                      rsp_o
);
  import sra_pkg::*;

  ctrl_cmd_t cmd;

  sra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  sra_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .PTR_WIDTH (PTR_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .action_i       (req_i.action),
    .req_size_i     (req_i.req_size),
    .align_log2_i   (req_i.align_log2),
    .grant_offset_o (rsp_o.grant_offset),
    .status_o       (rsp_o.status),
    .slot_index_o   (rsp_o.slot_index)
  );

endmodule

`default_nettype wire

/* sim/staging_ring_allocator_tb.sv */
// staging_ring_allocator_tb: self-checking bench for the staging ring allocator
// drives request words, predicts every response word and checks them in order
// depends on sra_pkg, sra_ifs and staging_ring_allocator
`timescale 1ns / 1ps

module staging_ring_allocator_tb;
  import sra_pkg::*;

  localparam int unsigned NUM_SLOTS  = 4;
  localparam int unsigned PTR_W      = 29;
  localparam int unsigned PHASE_REQS = 160;
  localparam int unsigned FINAL_REQS = 150;
  localparam int unsigned QUIET_MAX  = 5000;

  typedef struct {
    action_e            act;
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] alog;
  } req_item_t;

  typedef struct {
    logic [OFF_W-1:0]  offset;
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } grant_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CAP_W-1:0]  cfg_wdata_i;

  sra_req_if req_if ();
  sra_rsp_if rsp_if ();

  staging_ring_allocator #(
    .NUM_SLOTS(NUM_SLOTS),
    .PTR_WIDTH(PTR_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // allocator state as the testbench sees it
  logic [CAP_W-1:0] cap_bytes;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] batch_base;
  logic             batch_live;
  int unsigned      fill_slot;
  int unsigned      drain_slot;
  int unsigned      closed_cnt;
  logic [PTR_W-1:0] ext_start [NUM_SLOTS];
  logic [PTR_W-1:0] ext_end   [NUM_SLOTS];

  req_item_t   req_backlog [$];
  grant_t      grants_due  [$];
  req_item_t   next_req;
  grant_t      seen_grant;
  int unsigned err_count;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned quiet_cycles;
  bit          idle_on;

  logic [CAP_W-1:0] cap_plan [9] = '{
    CAP_W'(1), CAP_W'(0), CAP_W'(268435456), {CAP_W{1'b1}}, CAP_W'(4096),
    CAP_W'(1000), CAP_W'(300), CAP_W'(65536), CAP_W'(1048576)
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic grant_t alloc_step(action_e act, logic [SIZE_W-1:0] size,
                                        logic [ALIGN_W-1:0] alog);
    logic [63:0] amask;
    logic [63:0] cand;
    logic [63:0] offset;
    logic        fits;
    int unsigned s;
    grant_t      g;
    g.offset = '0;
    g.status = ST_OK;
    g.slot   = SLOT_W'(fill_slot);
    case (act)
      ACT_ACQUIRE: begin
        amask = (64'd1 << alog) - 64'd1;
        cand  = (64'(tail_ptr) + amask) & ~amask;
        if (size > cap_bytes) begin
          g.status = ST_TOO_LARGE;
        end else if (!batch_live && closed_cnt >= NUM_SLOTS) begin
          g.status = ST_NO_SLOT;
        end else begin
          offset = cand;
          fits   = 1'b1;
          if (head_ptr <= tail_ptr) begin
            // no room before the end: wrap to zero if it clears the head
            if (cand + 64'(size) > 64'(cap_bytes)) begin
              offset = '0;
              fits   = (size < head_ptr);
            end
          end else begin
            fits = (cand + 64'(size) < 64'(head_ptr));
          end
          if (!fits && (closed_cnt != 0 || batch_live)) begin
            g.status = ST_NO_SPACE;
          end else begin
            // an idle ring restarts from offset zero
            if (!fits) begin
              head_ptr = '0;
              offset   = '0;
            end
            if (!batch_live) begin
              batch_base = offset[PTR_W-1:0];
              batch_live = 1'b1;
            end
            tail_ptr = PTR_W'(offset + 64'(size));
            g.offset = offset[OFF_W-1:0];
          end
        end
      end
      ACT_FLUSH: begin
        s = fill_slot % NUM_SLOTS;
        if (!batch_live) begin
          g.status = ST_NOTHING_FLUSH;
        end else begin
          ext_start[s] = batch_base;
          ext_end[s]   = tail_ptr;
          batch_live   = 1'b0;
          closed_cnt++;
          fill_slot    = (s + 1) % NUM_SLOTS;
          g.slot       = SLOT_W'(s);
        end
      end
      ACT_RETIRE: begin
        s = drain_slot % NUM_SLOTS;
        if (closed_cnt == 0) begin
          g.status = ST_NOTHING_RETIRE;
        end else begin
          // an empty batch leaves the head where it is
          if (ext_start[s] != ext_end[s]) head_ptr = ext_end[s];
          closed_cnt--;
          drain_slot = (s + 1) % NUM_SLOTS;
          g.slot     = SLOT_W'(s);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic req_item_t rand_request(logic [CAP_W-1:0] cap);
    req_item_t   it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50)      it.act = ACT_ACQUIRE;
    else if (sel < 70) it.act = ACT_FLUSH;
    else if (sel < 90) it.act = ACT_RETIRE;
    else if (sel < 95) it.act = ACT_NOP;
    else               it.act = action_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       it.size = SIZE_W'($urandom);
      1:       it.size = cap + SIZE_W'($urandom_range(0, 3));
      2:       it.size = cap;
      default: it.size = SIZE_W'($urandom_range(0, 32'(cap) / 4 + 1));
    endcase
    if ($urandom_range(0, 3) == 0) it.alog = ALIGN_W'($urandom_range(0, 15));
    else                           it.alog = ALIGN_W'($urandom_range(0, 4));
    return it;
  endfunction

  task automatic add_req(action_e act, logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] alog);
    req_item_t it;
    it.act  = act;
    it.size = size;
    it.alog = alog;
    req_backlog.push_back(it);
  endtask

  // wait until every word has gone through and been answered
  task automatic drain();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || grants_due.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_bytes = cap;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        grants_due.push_back(alloc_step(action_e'(req_if.action), req_if.req_size,
                                        req_if.align_log2));
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          next_req = req_backlog.pop_front();
          req_if.valid      <= 1'b1;
          req_if.action     <= next_req.act;
          req_if.req_size   <= next_req.size;
          req_if.align_log2 <= next_req.alog;
          if (idle_on && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 19);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (grants_due.size() == 0) begin
          $error("response word with no request outstanding");
          err_count++;
        end else begin
          seen_grant = grants_due.pop_front();
          if (rsp_if.grant_offset !== seen_grant.offset) begin
            $error("grant_offset mismatch: expected %0d, got %0d",
                   seen_grant.offset, rsp_if.grant_offset);
            err_count++;
          end
          if (rsp_if.status !== seen_grant.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   seen_grant.status, rsp_if.status);
            err_count++;
          end
          if (rsp_if.slot_index !== seen_grant.slot) begin
            $error("slot_index mismatch: expected %0d, got %0d",
                   seen_grant.slot, rsp_if.slot_index);
            err_count++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 11) == 0) snk_gap = $urandom_range(1, 19);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_NOP;
    req_if.req_size   = '0;
    req_if.align_log2 = '0;
    rsp_if.ready      = 1'b0;
    err_count         = 0;
    quiet_cycles      = 0;
    idle_on           = 1'b1;
    cap_bytes         = CAP_RESET;
    head_ptr          = '0;
    tail_ptr          = '0;
    batch_base        = '0;
    batch_live        = 1'b0;
    fill_slot         = 0;
    drain_slot        = 0;
    closed_cnt        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset capacity
    add_req(ACT_RETIRE, '0, '0);
    add_req(ACT_FLUSH, '0, '0);
    add_req(ACT_NOP, {SIZE_W{1'b1}}, {ALIGN_W{1'b1}});
    add_req(ACT_ACQUIRE, {SIZE_W{1'b1}}, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(268435456), '0);
    add_req(ACT_ACQUIRE, '0, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(1), ALIGN_W'(15));
    add_req(ACT_ACQUIRE, SIZE_W'(1), ALIGN_W'(15));
    add_req(ACT_ACQUIRE, SIZE_W'(1048576), '0);
    add_req(ACT_FLUSH, '0, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(4000), ALIGN_W'(12));
    add_req(ACT_FLUSH, '0, '0);
    add_req(ACT_ACQUIRE, '0, ALIGN_W'(3));
    add_req(ACT_FLUSH, '0, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(10), ALIGN_W'(1));
    add_req(ACT_FLUSH, '0, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(10), '0);
    add_req(ACT_RETIRE, '0, '0);
    add_req(ACT_RETIRE, '0, '0);
    add_req(ACT_RETIRE, '0, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(1048000), '0);
    add_req(ACT_RETIRE, '0, '0);
    add_req(ACT_ACQUIRE, SIZE_W'(1048576), '0);
    add_req(ACT_FLUSH, '0, '0);
    add_req(ACT_RETIRE, '0, '0);
    drain();

    // random words over a range of ring sizes, extremes included
    foreach (cap_plan[i]) begin
      write_capacity(cap_plan[i]);
      repeat (PHASE_REQS) req_backlog.push_back(rand_request(cap_bytes));
      drain();
    end

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    write_capacity(CAP_W'(8192));
    repeat (FINAL_REQS) req_backlog.push_back(rand_request(cap_bytes));
    drain();

    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* staging_ring_allocator.f */
rtl/core/sra_pkg.sv
rtl/core/sra_ifs.sv
rtl/core/sra_ctrl.sv
rtl/core/sra_dp.sv
rtl/core/staging_ring_allocator.sv
sim/staging_ring_allocator_tb.sv
